// ----- src/deadline_ordered_task_queue_top_assert.svh -----
// ----------------------------------------------------------------------------
// deadline ordered task queue assertion macros
// concurrent checks, empty when SYNTHESIS is defined
// ----------------------------------------------------------------------------
`ifndef DEADLINE_ORDERED_TASK_QUEUE_TOP_ASSERT_SVH
`define DEADLINE_ORDERED_TASK_QUEUE_TOP_ASSERT_SVH

`ifndef SYNTHESIS
// property must hold at every clock edge outside reset
`define DOTQ_ASSERT(label, clk, rstn, prop) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("dotq assertion failed");
// condition must never be true
`define DOTQ_ASSERT_NEVER(label, clk, rstn, cond) \
    `DOTQ_ASSERT(label, clk, rstn, !(cond))
`else
`define DOTQ_ASSERT(label, clk, rstn, prop)
`define DOTQ_ASSERT_NEVER(label, clk, rstn, cond)
`endif

`endif

// ----- src/dotq_pkg.sv -----
// ----------------------------------------------------------------------------
// dotq_pkg
// shared widths, operation and status codes, sequencer states
// ----------------------------------------------------------------------------
`default_nettype none

package dotq_pkg;

    localparam int FUNC_W   = 2;
    localparam int TASK_W   = 16;
    localparam int DL_W     = 32;
    localparam int STATUS_W = 3;
    localparam int ENTRY_W  = TASK_W + DL_W;

    localparam logic [FUNC_W-1:0] FUNC_ENQUEUE = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_POLL    = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_CLOSE   = 2'd2;

    localparam logic [STATUS_W-1:0] STAT_ACCEPTED  = 3'd0;
    localparam logic [STATUS_W-1:0] STAT_FULL      = 3'd1;
    localparam logic [STATUS_W-1:0] STAT_DELIVERED = 3'd2;
    localparam logic [STATUS_W-1:0] STAT_NOT_DUE   = 3'd3;
    localparam logic [STATUS_W-1:0] STAT_FINISHED  = 3'd4;

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_SCAN   = 4'b0010,
        S_DECIDE = 4'b0100,
        S_SHIFT  = 4'b1000
    } state_t;

    // operands of the shared deadline comparator
    typedef struct packed {
        logic [DL_W-1:0] lhs;
        logic [DL_W-1:0] rhs;
    } cmp_req_t;

endpackage

`default_nettype wire

// ----- src/dotq_if.sv -----
// ----------------------------------------------------------------------------
// dotq channel interfaces
// request and response channels with valid / ready handshake
// ----------------------------------------------------------------------------
`default_nettype none

interface dotq_req_if
    import dotq_pkg::*;
();
    logic                valid;
    logic                ready;
    logic [FUNC_W-1:0]   func;
    logic [TASK_W-1:0]   task_id;
    logic [DL_W-1:0]     deadline;
    logic [DL_W-1:0]     current_time;

    modport source (output valid, func, task_id, deadline, current_time, input ready);
    modport sink   (input valid, func, task_id, deadline, current_time, output ready);
endinterface

interface dotq_rsp_if
    import dotq_pkg::*;
();
    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [TASK_W-1:0]   out_task;

    modport source (output valid, status, out_task, input ready);
    modport sink   (input valid, status, out_task, output ready);
endinterface

`default_nettype wire

// ----- src/dotq_ram.sv -----
// ----------------------------------------------------------------------------
// dotq_ram
// generic single write port ram with one registered read port
// ----------------------------------------------------------------------------
`default_nettype none

module dotq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata <= mem_reg[raddr];
    end

endmodule

`default_nettype wire

// ----- src/dotq_cmp.sv -----
// ----------------------------------------------------------------------------
// dotq_cmp
// shared unsigned deadline comparator
// ----------------------------------------------------------------------------
`default_nettype none

module dotq_cmp
    import dotq_pkg::*;
(
    input  cmp_req_t operands,
    output logic     lt
);

    assign lt = operands.lhs < operands.rhs;

endmodule

`default_nettype wire

// ----- src/dotq_ctrl.sv -----
// ----------------------------------------------------------------------------
// dotq_ctrl
// sequencer: enqueue, close, earliest deadline scan, removal by shifting
// ----------------------------------------------------------------------------
`default_nettype none
`include "deadline_ordered_task_queue_top_assert.svh"

module dotq_ctrl
    import dotq_pkg::*;
#(
    parameter int QUEUE_DEPTH = 16
) (
    input  logic                             clk,
    input  logic                             rst_n,
    dotq_req_if.sink                         req,
    dotq_rsp_if.source                       rsp,
    output logic                             ram_we,
    output logic [$clog2(QUEUE_DEPTH)-1:0]   ram_waddr,
    output logic [ENTRY_W-1:0]               ram_wdata,
    output logic [$clog2(QUEUE_DEPTH)-1:0]   ram_raddr,
    input  logic [ENTRY_W-1:0]               ram_rdata,
    output cmp_req_t                         cmp_req,
    input  logic                             cmp_lt
);

    localparam int AW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    state_t              state_reg, state_next;
    logic [CW-1:0]       count_reg, count_next;
    logic                closed_reg, closed_next;
    logic [AW-1:0]       idx_reg, idx_next;
    logic [AW-1:0]       best_idx_reg, best_idx_next;
    logic [DL_W-1:0]     best_dl_reg, best_dl_next;
    logic [TASK_W-1:0]   best_task_reg, best_task_next;
    logic [DL_W-1:0]     now_reg, now_next;
    logic                out_valid_reg, out_valid_next;
    logic [STATUS_W-1:0] out_status_reg, out_status_next;
    logic [TASK_W-1:0]   out_task_reg, out_task_next;

    logic                in_ready;
    logic                in_fire;
    logic                out_fire;
    logic                load_res;
    logic [STATUS_W-1:0] res_status;
    logic [TASK_W-1:0]   res_task;
    logic [DL_W-1:0]     rd_dl;
    logic [TASK_W-1:0]   rd_task;
    logic [CW-1:0]       count_last;
    logic [CW-1:0]       idx_plus2;

    assign in_ready   = (state_reg == S_IDLE) && (!out_valid_reg || rsp.ready);
    assign in_fire    = req.valid && in_ready;
    assign out_fire   = out_valid_reg && rsp.ready;
    assign req.ready  = in_ready;

    assign rsp.valid    = out_valid_reg;
    assign rsp.status   = out_status_reg;
    assign rsp.out_task = out_task_reg;

    assign rd_dl      = ram_rdata[DL_W-1:0];
    assign rd_task    = ram_rdata[DL_W +: TASK_W];
    assign count_last = count_reg - CW'(1);
    assign idx_plus2  = CW'(idx_reg) + CW'(2);

    // scan compares the fresh entry, decide compares the current tick
    always_comb
    begin
        cmp_req.rhs = best_dl_reg;
        if (state_reg == S_SCAN)
        begin
            cmp_req.lhs = rd_dl;
        end
        else
        begin
            cmp_req.lhs = now_reg;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        closed_next    = closed_reg;
        idx_next       = idx_reg;
        best_idx_next  = best_idx_reg;
        best_dl_next   = best_dl_reg;
        best_task_next = best_task_reg;
        now_next       = now_reg;
        load_res       = 1'b0;
        res_status     = STAT_NOT_DUE;
        res_task       = '0;
        ram_we         = 1'b0;
        ram_waddr      = idx_reg;
        ram_wdata      = ram_rdata;
        ram_raddr      = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    now_next = req.current_time;
                    case (req.func)
                        FUNC_ENQUEUE:
                        begin
                            load_res = 1'b1;
                            if (count_reg == CW'(QUEUE_DEPTH))
                            begin
                                res_status = STAT_FULL;
                            end
                            else
                            begin
                                ram_we     = 1'b1;
                                ram_waddr  = count_reg[AW-1:0];
                                ram_wdata  = {req.task_id, req.deadline};
                                count_next = count_reg + CW'(1);
                                res_status = STAT_ACCEPTED;
                            end
                        end
                        FUNC_POLL:
                        begin
                            if (count_reg == '0)
                            begin
                                load_res   = 1'b1;
                                res_status = closed_reg ? STAT_FINISHED : STAT_NOT_DUE;
                            end
                            else
                            begin
                                ram_raddr  = '0;
                                idx_next   = '0;
                                state_next = S_SCAN;
                            end
                        end
                        FUNC_CLOSE:
                        begin
                            closed_next = 1'b1;
                            load_res    = 1'b1;
                            res_status  = STAT_ACCEPTED;
                        end
                        default:
                        begin
                            load_res   = 1'b1;
                            res_status = STAT_NOT_DUE;
                        end
                    endcase
                end
            end
            S_SCAN:
            begin
                // strict compare keeps the oldest entry among equal deadlines
                if ((idx_reg == '0) || cmp_lt)
                begin
                    best_idx_next  = idx_reg;
                    best_dl_next   = rd_dl;
                    best_task_next = rd_task;
                end
                if (CW'(idx_reg) == count_last)
                begin
                    state_next = S_DECIDE;
                end
                else
                begin
                    idx_next  = idx_reg + AW'(1);
                    ram_raddr = idx_reg + AW'(1);
                end
            end
            S_DECIDE:
            begin
                load_res = 1'b1;
                if (!cmp_lt)
                begin
                    res_status = STAT_DELIVERED;
                    res_task   = best_task_reg;
                    if (CW'(best_idx_reg) == count_last)
                    begin
                        count_next = count_last;
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        ram_raddr  = best_idx_reg + AW'(1);
                        idx_next   = best_idx_reg;
                        state_next = S_SHIFT;
                    end
                end
                else
                begin
                    res_status = STAT_NOT_DUE;
                    state_next = S_IDLE;
                end
            end
            S_SHIFT:
            begin
                // entry idx+1 arrives from the ram and moves down one slot
                ram_we    = 1'b1;
                ram_waddr = idx_reg;
                ram_wdata = ram_rdata;
                if (idx_plus2 == count_reg)
                begin
                    count_next = count_last;
                    state_next = S_IDLE;
                end
                else
                begin
                    idx_next  = idx_reg + AW'(1);
                    ram_raddr = idx_plus2[AW-1:0];
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_status_next = out_status_reg;
        out_task_next   = out_task_reg;
        if (load_res)
        begin
            out_valid_next  = 1'b1;
            out_status_next = res_status;
            out_task_next   = res_task;
        end
        else if (out_fire)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            closed_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            closed_reg    <= closed_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg        <= idx_next;
        best_idx_reg   <= best_idx_next;
        best_dl_reg    <= best_dl_next;
        best_task_reg  <= best_task_next;
        now_reg        <= now_next;
        out_status_reg <= out_status_next;
        out_task_reg   <= out_task_next;
    end

    `DOTQ_ASSERT_NEVER(a_count_max, clk, rst_n, count_reg > CW'(QUEUE_DEPTH))
    `DOTQ_ASSERT_NEVER(a_scan_idx, clk, rst_n, (state_reg == S_SCAN) && (CW'(idx_reg) >= count_reg))
    `DOTQ_ASSERT(a_poll_scan, clk, rst_n, in_fire && (req.func == FUNC_POLL) && (count_reg != '0) |=> (state_reg == S_SCAN))
    `DOTQ_ASSERT_NEVER(a_no_overwrite, clk, rst_n, load_res && out_valid_reg && !rsp.ready)

endmodule

`default_nettype wire

// ----- src/deadline_ordered_task_queue_top.sv -----
// ----------------------------------------------------------------------------
// deadline_ordered_task_queue_top
// bounded task queue that hands out tasks in deadline order
// ----------------------------------------------------------------------------
// req carries one operation per transaction: enqueue a task id with its
// deadline, poll with the current tick, or close. rsp returns exactly one
// status transaction per request, with the task id on a delivery.
// enqueue and close finish in the accept cycle; the response is valid on
// the next cycle. a poll on a non-empty queue reads the entries one per
// cycle through the single ram read port and one deadline comparator:
// a scan over every stored task, a decide step, then moving the later
// entries down a slot after a removal.
// req.ready is high only while the sequencer is idle and the response
// register is empty or being taken, so a stalled receiver holds back
// new requests without losing any response.
// reset empties the queue and clears the closed flag; no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module deadline_ordered_task_queue_top
    import dotq_pkg::*;
#(
    parameter int QUEUE_DEPTH = 16
) (
    input  logic       clk,
    input  logic       rst_n,
    dotq_req_if.sink   req,
    dotq_rsp_if.source rsp
);

    localparam int AW = $clog2(QUEUE_DEPTH);

    logic               ram_we;
    logic [AW-1:0]      ram_waddr;
    logic [ENTRY_W-1:0] ram_wdata;
    logic [AW-1:0]      ram_raddr;
    logic [ENTRY_W-1:0] ram_rdata;
    cmp_req_t           cmp_req;
    logic               cmp_lt;

    dotq_ctrl #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .rsp       (rsp),
        .ram_we    (ram_we),
        .ram_waddr (ram_waddr),
        .ram_wdata (ram_wdata),
        .ram_raddr (ram_raddr),
        .ram_rdata (ram_rdata),
        .cmp_req   (cmp_req),
        .cmp_lt    (cmp_lt)
    );

    dotq_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    dotq_cmp u_cmp (
        .operands (cmp_req),
        .lt       (cmp_lt)
    );

endmodule

`default_nettype wire

// ----- verif/tb_deadline_ordered_task_queue_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_deadline_ordered_task_queue_top
// self-checking bench for the deadline ordered task queue: a directed
// opening of edge cases, then phases of random enqueue / poll / close
// traffic with random idle on both channels, checked against a shadow
// queue held in a small scoreboard
// ----------------------------------------------------------------------------

module tb_deadline_ordered_task_queue_top
    import dotq_pkg::*;
();

    localparam int QDEPTH        = 16;
    localparam int RANDOM_ITEMS  = 950;
    localparam int PHASE_LEN     = 50;
    localparam int STALL_LIMIT   = 2000;
    localparam int DRAIN_CYCLES  = 2 * QDEPTH + 8;
    localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [TASK_W-1:0]   out_task;
    } queue_reply_t;

    typedef struct packed {
        logic [FUNC_W-1:0] func;
        logic [TASK_W-1:0] task_id;
        logic [DL_W-1:0]   deadline;
        logic [DL_W-1:0]   current_time;
    } queue_op_t;

    // shadow copy of the queue, slots kept oldest first
    class dotq_scoreboard;
        logic [TASK_W-1:0] slot_task[QDEPTH];
        logic [DL_W-1:0]   slot_deadline[QDEPTH];
        int unsigned       fill;
        bit                closed;
        queue_reply_t      pending_replies[$];
        int unsigned       errors;

        function new();
            fill   = 0;
            closed = 1'b0;
            errors = 0;
        endfunction

        task report_mismatch(string msg);
            $display("mismatch at %0t: %s", $realtime, msg);
            errors++;
        endtask

        function void note_request(queue_op_t op);
            queue_reply_t reply;
            int unsigned  best;
            reply.status   = STAT_NOT_DUE;
            reply.out_task = '0;
            if (op.func == FUNC_ENQUEUE)
            begin
                if (fill >= QDEPTH)
                begin
                    reply.status = STAT_FULL;
                end
                else
                begin
                    slot_task[fill]     = op.task_id;
                    slot_deadline[fill] = op.deadline;
                    fill++;
                    reply.status = STAT_ACCEPTED;
                end
            end
            else if (op.func == FUNC_POLL)
            begin
                if (fill == 0)
                begin
                    reply.status = closed ? STAT_FINISHED : STAT_NOT_DUE;
                end
                else
                begin
                    // strict compare keeps the oldest of equal deadlines
                    best = 0;
                    for (int k = 1; k < fill; k++)
                    begin
                        if (slot_deadline[k] < slot_deadline[best])
                            best = k;
                    end
                    if (slot_deadline[best] <= op.current_time)
                    begin
                        reply.status   = STAT_DELIVERED;
                        reply.out_task = slot_task[best];
                        for (int k = best; k + 1 < fill; k++)
                        begin
                            slot_task[k]     = slot_task[k + 1];
                            slot_deadline[k] = slot_deadline[k + 1];
                        end
                        fill--;
                    end
                end
            end
            else if (op.func == FUNC_CLOSE)
            begin
                closed       = 1'b1;
                reply.status = STAT_ACCEPTED;
            end
            pending_replies.push_back(reply);
        endfunction

        task check_response(logic [STATUS_W-1:0] status, logic [TASK_W-1:0] out_task);
            queue_reply_t want;
            if (pending_replies.size() == 0)
            begin
                report_mismatch($sformatf("unexpected response status %0d task %0h",
                                          status, out_task));
            end
            else
            begin
                want = pending_replies.pop_front();
                if (status !== want.status)
                    report_mismatch($sformatf("status %0d, expected %0d",
                                              status, want.status));
                if (out_task !== want.out_task)
                    report_mismatch($sformatf("out_task %0h, expected %0h",
                                              out_task, want.out_task));
            end
        endtask
    endclass

    logic clk = 1'b0;
    logic rst_n;

    dotq_req_if req_ch ();
    dotq_rsp_if rsp_ch ();

    deadline_ordered_task_queue_top #(
        .QUEUE_DEPTH (QDEPTH)
    ) uut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    dotq_scoreboard sb = new();
    bit             quiet_gaps;
    int unsigned    stall_cycles;

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    function automatic queue_op_t make_op(logic [FUNC_W-1:0] func, logic [TASK_W-1:0] id,
                                          logic [DL_W-1:0] dl, logic [DL_W-1:0] now);
        queue_op_t op;
        op.func         = func;
        op.task_id      = id;
        op.deadline     = dl;
        op.current_time = now;
        return op;
    endfunction

    // called at a rising edge; returns at the edge where the transaction is taken
    task automatic send_request(queue_op_t op);
        int gap;
        gap = quiet_gaps ? 0 : $urandom_range(0, 10);
        if (gap > 0)
        begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_ch.func         <= op.func;
        req_ch.task_id      <= op.task_id;
        req_ch.deadline     <= op.deadline;
        req_ch.current_time <= op.current_time;
        req_ch.valid        <= 1'b1;
        do @(posedge clk); while (!req_ch.ready);
    endtask

    // transaction monitor and watchdog
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (req_ch.valid && req_ch.ready)
                sb.note_request(make_op(req_ch.func, req_ch.task_id, req_ch.deadline,
                                        req_ch.current_time));
            if (rsp_ch.valid && rsp_ch.ready)
                sb.check_response(rsp_ch.status, rsp_ch.out_task);
            if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
                stall_cycles = 0;
            else
                stall_cycles++;
            if (stall_cycles >= STALL_LIMIT)
            begin
                $display("watchdog: no transaction for %0d cycles", STALL_LIMIT);
                $display("Verification failed");
                $finish;
            end
        end
    end

    // response side with random back-pressure
    initial
    begin
        int gap;
        do @(posedge clk); while (!rst_n);
        forever
        begin
            gap = quiet_gaps ? 0 : $urandom_range(0, 10);
            if (gap > 0)
            begin
                rsp_ch.ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            rsp_ch.ready <= 1'b1;
            do @(posedge clk); while (!rsp_ch.valid);
        end
    end

    initial
    begin
        logic [DL_W-1:0]   tick;
        logic [DL_W-1:0]   last_dl;
        logic [DL_W-1:0]   dl;
        logic [DL_W-1:0]   now;
        logic [FUNC_W-1:0] func;
        int                enq_pct;
        int                r;

        stall_cycles         = 0;
        quiet_gaps           = 1'b0;
        rst_n                = 1'b0;
        req_ch.valid        <= 1'b0;
        req_ch.func         <= FUNC_ENQUEUE;
        req_ch.task_id      <= '0;
        req_ch.deadline     <= '0;
        req_ch.current_time <= '0;
        rsp_ch.ready        <= 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty open queue, unused code, extreme ids and deadlines
        send_request(make_op(FUNC_POLL, 16'h1234, 32'h0, 32'hFFFF_FFFF));
        send_request(make_op(FUNC_UNUSED, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
        send_request(make_op(FUNC_ENQUEUE, 16'h0000, 32'h0, 32'h0));
        send_request(make_op(FUNC_ENQUEUE, 16'hFFFF, 32'hFFFF_FFFF, 32'h0));
        // fill with equal deadlines, then one more is dropped
        for (int i = 0; i < QDEPTH - 2; i++)
            send_request(make_op(FUNC_ENQUEUE, TASK_W'(16'h0A00 + i), 32'd100, 32'h0));
        send_request(make_op(FUNC_ENQUEUE, 16'hBEEF, 32'h0, 32'h0));
        send_request(make_op(FUNC_POLL, 16'h0, 32'h0, 32'h0));
        send_request(make_op(FUNC_POLL, 16'h0, 32'h0, 32'd99));
        send_request(make_op(FUNC_POLL, 16'h0, 32'h0, 32'd100));
        // enqueue after close is still accepted, close twice
        send_request(make_op(FUNC_CLOSE, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
        send_request(make_op(FUNC_ENQUEUE, 16'h5A5A, 32'hFFFF_FFFE, 32'h0));
        send_request(make_op(FUNC_CLOSE, 16'h0, 32'h0, 32'h0));

        tick    = $urandom();
        last_dl = tick;
        enq_pct = 50;
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (n % PHASE_LEN == 0)
            begin
                r = $urandom_range(0, 3);
                enq_pct    = (r == 0) ? 25 : (r == 1) ? 50 : (r == 2) ? 75 : 90;
                quiet_gaps = ($urandom_range(0, 3) == 0);
                if ($urandom_range(0, 2) == 0)
                    tick = $urandom();
            end

            r = $urandom_range(0, 99);
            if (r < enq_pct)
                func = FUNC_ENQUEUE;
            else if (r < 96)
                func = FUNC_POLL;
            else if (r < 98)
                func = FUNC_CLOSE;
            else
                func = FUNC_UNUSED;

            r = $urandom_range(0, 99);
            if (r < 60)
                dl = tick + $urandom_range(0, 300);
            else if (r < 70)
                dl = last_dl;
            else if (r < 80)
                dl = tick - $urandom_range(0, 50);
            else if (r < 90)
                dl = $urandom();
            else if (r < 95)
                dl = '0;
            else
                dl = '1;
            if (func == FUNC_ENQUEUE)
                last_dl = dl;

            if (func == FUNC_POLL)
                tick = tick + $urandom_range(0, 40);
            r = $urandom_range(0, 99);
            if (r < 70)
                now = tick;
            else if (r < 80)
                now = $urandom();
            else if (r < 88)
                now = '0;
            else if (r < 95)
                now = '1;
            else
                now = tick + $urandom_range(300, 5000);

            send_request(make_op(func, TASK_W'($urandom_range(0, 65535)), dl, now));
        end
        req_ch.valid <= 1'b0;

        while (sb.pending_replies.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (sb.errors == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
